### hdl/rgrt_pkg.sv
// rgrt_pkg: shared types, codes and constants for the rtp gap resend tracker
// no dependencies; imported by rgrt_ms_conv, rtp_gap_resend_tracker, rgrt_scoreboard and the testbench
`default_nettype none
package rgrt_pkg;

   localparam int RESEND_ENTRIES_DEF = 64;

   // field widths
   localparam int SEQ_W   = 16;
   localparam int TS_W    = 32;
   localparam int MS_W    = 29;
   localparam int RATE_W  = 18;
   localparam int TMO_W   = 16;
   localparam int EXP_W   = 7;
   localparam int OUTC_W  = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 18;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 120;

   // millisecond conversion: ts * 1000 is 42 bits, one quotient bit per step
   localparam int PROD_W     = 42;
   localparam int CONV_STEPS = 42;
   localparam int CNT_W      = 6;
   localparam logic [9:0]        MS_PER_S = 10'd1000;
   localparam logic [MS_W-1:0]   MS_MAX   = 29'h1FFF_FFFF;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SESSION_READY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_RATE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RESEND_TMO    = 2'd2;

   localparam logic [RATE_W-1:0] RATE_RESET = 18'd44100;
   localparam logic [TMO_W-1:0]  TMO_RESET  = 16'd500;

   // header bytes
   localparam logic [7:0] HDR_V2          = 8'h80;
   localparam logic [7:0] HDR_V2_MARK     = 8'h90;
   localparam logic [7:0] TYPE_SYNC_A     = 8'h53;
   localparam logic [7:0] TYPE_SYNC_B     = 8'h54;
   localparam logic [7:0] TYPE_SYNC_START = 8'hD4;
   localparam logic [7:0] TYPE_AUDIO      = 8'h60;
   localparam logic [7:0] TYPE_AUDIO_START= 8'hE0;
   localparam logic [7:0] TYPE_RESEND     = 8'h56;

   localparam logic [SEQ_W-1:0] GAP_LIMIT = 16'h8000;

   // result outcome codes
   localparam logic [OUTC_W-1:0] OUT_BAD_VERSION = 3'd0;
   localparam logic [OUTC_W-1:0] OUT_NOT_READY   = 3'd1;
   localparam logic [OUTC_W-1:0] OUT_IGNORED     = 3'd2;
   localparam logic [OUTC_W-1:0] OUT_UNHANDLED   = 3'd3;
   localparam logic [OUTC_W-1:0] OUT_AUDIO       = 3'd4;
   localparam logic [OUTC_W-1:0] OUT_RESEND_HIT  = 3'd5;
   localparam logic [OUTC_W-1:0] OUT_RESEND_MISS = 3'd6;
   localparam logic [OUTC_W-1:0] OUT_FLUSHED     = 3'd7;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_MATCH,
      ST_PLACE,
      ST_SWEEP,
      ST_RESEND,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              start;
      logic [TS_W-1:0]   ts;
      logic [RATE_W-1:0] rate;
   } conv_req_type;

   typedef struct packed {
      logic            done;
      logic [MS_W-1:0] ms;
   } conv_rsp_type;

endpackage
`default_nettype wire

### hdl/rgrt_ms_conv.sv
// rgrt_ms_conv: timestamp to milliseconds, floor(ts * 1000 / rate), saturating
// restoring divider, one quotient bit per cycle; uses rgrt_pkg
`default_nettype none
module rgrt_ms_conv (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire rgrt_pkg::conv_req_type conv_req,
   output rgrt_pkg::conv_rsp_type     conv_rsp
);
   import rgrt_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [PROD_W-1:0]   dvd_ff, dvd_in;
   logic [RATE_W-1:0]   rem_ff, rem_in;
   logic [RATE_W-1:0]   rate_ff, rate_in;
   logic                zero_ff, zero_in;
   logic [RATE_W:0]     trial;
   logic                ge;

   assign trial = {rem_ff, dvd_ff[PROD_W-1]};
   assign ge    = trial >= {1'b0, rate_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      rate_in = rate_ff;
      zero_in = zero_ff;
      if (conv_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(CONV_STEPS);
         dvd_in  = {10'b0, conv_req.ts} * {32'b0, MS_PER_S};
         rem_in  = '0;
         rate_in = conv_req.rate;
         zero_in = conv_req.rate == '0;
      end else if (busy_ff) begin
         rem_in = ge ? RATE_W'(trial - {1'b0, rate_ff}) : trial[RATE_W-1:0];
         dvd_in = {dvd_ff[PROD_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      rate_ff <= rate_in;
      zero_ff <= zero_in;
   end

   assign conv_rsp.done = done_ff;
   assign conv_rsp.ms   = (zero_ff || (|dvd_ff[PROD_W-1:MS_W])) ? MS_MAX : dvd_ff[MS_W-1:0];

endmodule
`default_nettype wire

### hdl/rtp_gap_resend_tracker.sv
// rtp_gap_resend_tracker: sequence gap tracker with resend table and playback hold
// depends on rgrt_pkg and rgrt_ms_conv
//
//  channel  dir  handshake              payload
//  req_     in   req_tvalid/req_tready  tuser command, tdata header fields
//  rsp_     out  rsp_tvalid/rsp_tready  tuser outcome, tdata result fields
//  csr_     in   csr_we                 csr_index, csr_wdata
//
// a flush or a header that is dropped early goes from idle straight to done; an
// audio or resend beat runs a bit-serial millisecond conversion and then one
// table scan; a gap adds a match scan and a placement walk that fills the
// missing numbers into free table slots
// the table memories have one read port, so every scan visits one entry a cycle
// reset is synchronous; valid bits clear at once, no clearing pass is needed
// req_tready is low while a beat is in work; a finished result waits in the
// output register and the next beat may enter meanwhile
`default_nettype none
module rtp_gap_resend_tracker #(
   parameter int RESEND_ENTRIES = rgrt_pkg::RESEND_ENTRIES_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   // [7:0] first_byte, [15:8] type_byte, [31:16] sequence_req, [63:32] rtp_timestamp
   input  wire logic [rgrt_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] command
   input  wire logic                            req_tuser,
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [28:0] timestamp_ms, [29] request_valid, [45:30] request_number,
   // [61:46] request_start, [77:62] request_count, [106:78] hold_timestamp,
   // [113:107] expired_count, [114] table_overflow, [119:115] zero
   output      logic [rgrt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [2:0] outcome
   output      logic [rgrt_pkg::OUTC_W-1:0]     rsp_tuser,
   input  wire logic                            csr_we,
   input  wire logic [rgrt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [rgrt_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rgrt_pkg::*;

   localparam int N  = RESEND_ENTRIES;
   localparam int IW = (N > 1) ? $clog2(N) : 1;
   localparam int NW = $clog2(N + 1);
   localparam logic [NW-1:0] N_CNT = NW'(N);

   // control state
   state_type            state_ff, state_in;
   logic                 session_ff, session_in;
   logic [RATE_W-1:0]    rate_ff, rate_in;
   logic [TMO_W-1:0]     tmo_ff, tmo_in;
   logic [SEQ_W-1:0]     exp_ff, exp_in;
   logic                 act_ff, act_in;
   logic [SEQ_W-1:0]     reqcnt_ff, reqcnt_in;
   logic [N-1:0]         valid_ff, valid_in;
   logic [NW-1:0]        count_ff, count_in;
   logic [MS_W-1:0]      hold_ff, hold_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [NW-1:0]        scan_ff, scan_in;
   logic                 dact_ff, dact_in;

   // per-beat working registers
   logic                 resend_ff, resend_in;
   logic [SEQ_W-1:0]     seq_ff, seq_in;
   logic [OUTC_W-1:0]    outc_ff, outc_in;
   logic [MS_W-1:0]      ms_ff, ms_in;
   logic                 rqv_ff, rqv_in;
   logic [SEQ_W-1:0]     rqn_ff, rqn_in;
   logic [SEQ_W-1:0]     start_ff, start_in;
   logic [SEQ_W-1:0]     gap_ff, gap_in;
   logic [EXP_W-1:0]     expd_ff, expd_in;
   logic                 ovf_ff, ovf_in;
   logic                 any_ff, any_in;
   logic [MS_W-1:0]      oldest_ff, oldest_in;
   logic                 found_ff, found_in;
   logic [NW-1:0]        free_ff, free_in;
   logic [NW-1:0]        matched_ff, matched_in;
   logic [NW-1:0]        placed_ff, placed_in;
   logic [SEQ_W-1:0]     k_ff, k_in;
   logic [NW-1:0]        slot_ff, slot_in;
   logic [IW-1:0]        didx_ff, didx_in;
   logic [N-1:0]         present_ff, present_in;
   logic [OUTC_W-1:0]    rsp_user_ff, rsp_user_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // table memories
   logic [SEQ_W-1:0]     seq_mem [N];
   logic [MS_W-1:0]      time_mem [N];
   logic [SEQ_W-1:0]     rd_seq_ff;
   logic [MS_W-1:0]      rd_time_ff;
   logic [IW-1:0]        rd_addr;
   logic                 seq_we, time_we;
   logic [IW-1:0]        wr_addr;
   logic [SEQ_W-1:0]     wr_seq;

   // decode and scan helpers
   logic                 accept;
   logic [7:0]           type_raw, type_eff;
   logic                 hdr_ok, is_ignored, is_audio, is_start, is_resend;
   logic                 scan_issue, scan_done, load_rsp;
   logic                 d_valid;
   logic [SEQ_W-1:0]     offset;
   logic                 in_range;
   logic                 is_stale;
   logic                 k_present;
   logic                 slot_valid;
   logic [SEQ_W-1:0]     eff_exp, new_gap;
   logic                 eff_act;
   logic [SEQ_W:0]       need;

   conv_req_type         conv_req;
   conv_rsp_type         conv_rsp;

   rgrt_ms_conv u_conv (
      .clock    (clock),
      .reset    (reset),
      .conv_req (conv_req),
      .conv_rsp (conv_rsp)
   );

   assign req_tready = state_ff == ST_IDLE;
   assign accept     = req_tvalid && req_tready;

   // type byte keeps bit 7 only for the two start marks
   assign type_raw   = req_tdata[15:8];
   assign type_eff   = (type_raw == TYPE_SYNC_START || type_raw == TYPE_AUDIO_START)
                       ? type_raw : {1'b0, type_raw[6:0]};
   assign hdr_ok     = req_tdata[7:0] == HDR_V2 || req_tdata[7:0] == HDR_V2_MARK;
   assign is_ignored = type_eff == TYPE_SYNC_A || type_eff == TYPE_SYNC_B ||
                       type_eff == TYPE_SYNC_START;
   assign is_start   = type_eff == TYPE_AUDIO_START;
   assign is_resend  = type_eff == TYPE_RESEND;
   assign is_audio   = type_eff == TYPE_AUDIO || is_start || is_resend;

   assign conv_req.start = accept && !req_tuser && hdr_ok && !is_ignored &&
                           is_audio && session_ff;
   assign conv_req.ts    = req_tdata[63:32];
   assign conv_req.rate  = rate_ff;

   // scans: issue one read a cycle, evaluate the registered read data in the next cycle
   assign scan_issue = scan_ff < N_CNT;
   assign scan_done  = (scan_ff == N_CNT) && !dact_ff;
   assign rd_addr    = scan_ff[IW-1:0];
   assign d_valid    = dact_ff && valid_ff[didx_ff];
   assign offset     = rd_seq_ff - start_ff;
   assign in_range   = offset < gap_ff;
   // wrapped age counts as stale too
   assign is_stale   = (rd_time_ff > ms_ff) ||
                       ({3'b0, tmo_ff} < MS_W'(ms_ff - rd_time_ff));
   assign k_present  = ({1'b0, k_ff} < (SEQ_W+1)'(N)) && present_ff[k_ff[IW-1:0]];
   assign slot_valid = valid_ff[slot_ff[IW-1:0]];
   assign need       = {1'b0, gap_ff} - {{(SEQ_W+1-NW){1'b0}}, matched_ff};

   // stream start reloads the expected number before the gap check
   assign eff_exp    = resend_ff ? exp_ff : (outc_ff == OUT_AUDIO && start_ff[0] ? seq_ff : exp_ff);
   assign eff_act    = act_ff || (outc_ff == OUT_AUDIO && start_ff[0]);
   assign new_gap    = seq_ff - eff_exp;

   assign load_rsp   = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = conv_req.start ? ST_CONV : ST_DONE;
         end
         ST_CONV: begin
            if (conv_rsp.done) begin
               if (resend_ff)                                   state_in = ST_RESEND;
               else if (eff_act && seq_ff != eff_exp && new_gap < GAP_LIMIT)
                                                                state_in = ST_MATCH;
               else                                             state_in = ST_SWEEP;
            end
         end
         ST_MATCH:  if (scan_done) state_in = ST_PLACE;
         ST_PLACE: begin
            if ({1'b0, k_ff} >= {1'b0, gap_ff} || placed_ff == free_ff || slot_ff == N_CNT)
               state_in = ST_SWEEP;
         end
         ST_SWEEP:  if (scan_done) state_in = ST_DONE;
         ST_RESEND: if (scan_done) state_in = ST_DONE;
         ST_DONE:   if (load_rsp)  state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and bookkeeping
   always_comb begin
      session_in = session_ff;
      rate_in    = rate_ff;
      tmo_in     = tmo_ff;
      exp_in     = exp_ff;
      act_in     = act_ff;
      reqcnt_in  = reqcnt_ff;
      valid_in   = valid_ff;
      count_in   = count_ff;
      hold_in    = hold_ff;
      scan_in    = scan_ff;
      dact_in    = 1'b0;
      didx_in    = rd_addr;
      resend_in  = resend_ff;
      seq_in     = seq_ff;
      outc_in    = outc_ff;
      ms_in      = ms_ff;
      rqv_in     = rqv_ff;
      rqn_in     = rqn_ff;
      start_in   = start_ff;
      gap_in     = gap_ff;
      expd_in    = expd_ff;
      ovf_in     = ovf_ff;
      any_in     = any_ff;
      oldest_in  = oldest_ff;
      found_in   = found_ff;
      free_in    = free_ff;
      matched_in = matched_ff;
      placed_in  = placed_ff;
      k_in       = k_ff;
      slot_in    = slot_ff;
      present_in = present_ff;
      seq_we     = 1'b0;
      time_we    = 1'b0;
      wr_addr    = didx_ff;
      wr_seq     = start_ff + k_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_tready) rsp_valid_in = 1'b0;

      if (csr_we) begin
         case (csr_index)
            CSR_SESSION_READY: session_in = csr_wdata[0];
            CSR_SAMPLE_RATE:   rate_in    = csr_wdata[RATE_W-1:0];
            CSR_RESEND_TMO:    tmo_in     = csr_wdata[TMO_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ms_in     = '0;
               rqv_in    = 1'b0;
               rqn_in    = '0;
               start_in  = '0;
               gap_in    = '0;
               expd_in   = '0;
               ovf_in    = 1'b0;
               seq_in    = req_tdata[31:16];
               resend_in = is_resend;
               // start_ff bit 0 carries the stream start mark until the gap check
               start_in[0] = conv_req.start && is_start;
               if (req_tuser) begin
                  outc_in  = OUT_FLUSHED;
                  valid_in = '0;
                  count_in = '0;
                  act_in   = 1'b0;
                  hold_in  = '0;
               end else if (!hdr_ok)     outc_in = OUT_BAD_VERSION;
               else if (is_ignored)      outc_in = OUT_IGNORED;
               else if (!is_audio)       outc_in = OUT_UNHANDLED;
               else if (!session_ff)     outc_in = OUT_NOT_READY;
               else                      outc_in = OUT_AUDIO;
            end
         end
         ST_CONV: begin
            if (conv_rsp.done) begin
               ms_in     = conv_rsp.ms;
               scan_in   = '0;
               found_in  = 1'b0;
               any_in    = 1'b0;
               oldest_in = MS_MAX;
               free_in   = '0;
               matched_in = '0;
               present_in = '0;
               start_in  = '0;
               if (!resend_ff) begin
                  if (eff_act && seq_ff != eff_exp) begin
                     rqv_in    = 1'b1;
                     rqn_in    = reqcnt_ff;
                     reqcnt_in = reqcnt_ff + 1'b1;
                     start_in  = eff_exp;
                     gap_in    = new_gap;
                  end
                  exp_in = seq_ff + 1'b1;
                  act_in = 1'b1;
               end
            end
         end
         ST_MATCH: begin
            if (scan_issue) begin
               scan_in = scan_ff + 1'b1;
               dact_in = 1'b1;
            end
            if (dact_ff) begin
               if (!valid_ff[didx_ff]) begin
                  free_in = free_ff + 1'b1;
               end else if (in_range) begin
                  time_we    = 1'b1;
                  matched_in = matched_ff + 1'b1;
                  if ({1'b0, offset} < (SEQ_W+1)'(N)) present_in[offset[IW-1:0]] = 1'b1;
               end
            end
            if (scan_done) begin
               ovf_in    = need > (SEQ_W+1)'(free_ff);
               k_in      = '0;
               slot_in   = '0;
               placed_in = '0;
            end
         end
         ST_PLACE: begin
            wr_addr = slot_ff[IW-1:0];
            if (state_in == ST_SWEEP) begin
               scan_in = '0;
            end else if (k_present) begin
               k_in = k_ff + 1'b1;
            end else if (slot_valid) begin
               slot_in = slot_ff + 1'b1;
            end else begin
               seq_we    = 1'b1;
               time_we   = 1'b1;
               valid_in[slot_ff[IW-1:0]] = 1'b1;
               count_in  = count_ff + 1'b1;
               placed_in = placed_ff + 1'b1;
               k_in      = k_ff + 1'b1;
               slot_in   = slot_ff + 1'b1;
            end
         end
         ST_SWEEP: begin
            if (scan_issue) begin
               scan_in = scan_ff + 1'b1;
               dact_in = 1'b1;
            end
            if (d_valid) begin
               if (is_stale) begin
                  valid_in[didx_ff] = 1'b0;
                  count_in = count_ff - 1'b1;
                  if (expd_ff != '1) expd_in = expd_ff + 1'b1;
               end else begin
                  any_in = 1'b1;
                  if (rd_time_ff < oldest_ff) oldest_in = rd_time_ff;
               end
            end
            if (scan_done) hold_in = any_ff ? oldest_ff : '0;
         end
         ST_RESEND: begin
            if (scan_issue) begin
               scan_in = scan_ff + 1'b1;
               dact_in = 1'b1;
            end
            if (d_valid && rd_seq_ff == seq_ff) begin
               valid_in[didx_ff] = 1'b0;
               count_in = count_ff - 1'b1;
               found_in = 1'b1;
            end
            if (scan_done) begin
               outc_in = found_ff ? OUT_RESEND_HIT : OUT_RESEND_MISS;
               if (count_ff == '0) hold_in = '0;
            end
         end
         ST_DONE: begin
            if (load_rsp) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = outc_ff;
               rsp_data_in  = {5'b0, ovf_ff, expd_ff, hold_ff, gap_ff, start_ff,
                               rqn_ff, rqv_ff, ms_ff};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         session_ff   <= 1'b0;
         rate_ff      <= RATE_RESET;
         tmo_ff       <= TMO_RESET;
         exp_ff       <= '0;
         act_ff       <= 1'b0;
         reqcnt_ff    <= '0;
         valid_ff     <= '0;
         count_ff     <= '0;
         hold_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         scan_ff      <= '0;
         dact_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         session_ff   <= session_in;
         rate_ff      <= rate_in;
         tmo_ff       <= tmo_in;
         exp_ff       <= exp_in;
         act_ff       <= act_in;
         reqcnt_ff    <= reqcnt_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         hold_ff      <= hold_in;
         rsp_valid_ff <= rsp_valid_in;
         scan_ff      <= scan_in;
         dact_ff      <= dact_in;
      end
   end

   always_ff @(posedge clock) begin
      resend_ff   <= resend_in;
      seq_ff      <= seq_in;
      outc_ff     <= outc_in;
      ms_ff       <= ms_in;
      rqv_ff      <= rqv_in;
      rqn_ff      <= rqn_in;
      start_ff    <= start_in;
      gap_ff      <= gap_in;
      expd_ff     <= expd_in;
      ovf_ff      <= ovf_in;
      any_ff      <= any_in;
      oldest_ff   <= oldest_in;
      found_ff    <= found_in;
      free_ff     <= free_in;
      matched_ff  <= matched_in;
      placed_ff   <= placed_in;
      k_ff        <= k_in;
      slot_ff     <= slot_in;
      didx_ff     <= didx_in;
      present_ff  <= present_in;
      rsp_user_ff <= rsp_user_in;
      rsp_data_ff <= rsp_data_in;
   end

   // resend table storage, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (seq_we)  seq_mem[wr_addr]  <= wr_seq;
      if (time_we) time_mem[wr_addr] <= ms_ff;
      rd_seq_ff  <= seq_mem[rd_addr];
      rd_time_ff <= time_mem[rd_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tdata  = rsp_data_ff;

   // fill count tracks the valid bits
   a_count: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(count_ff))
      else $error("fill count out of step with valid bits");

   // a resend request only comes with plain audio
   a_req_audio: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[29] |-> rsp_tuser == OUT_AUDIO)
      else $error("resend request on a non-audio result");

   // between beats a nonzero hold needs an outstanding entry
   a_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE && hold_ff != '0 |-> count_ff != '0)
      else $error("hold set with empty resend table");

endmodule
`default_nettype wire

### tb/rgrt_scoreboard.sv
// rgrt_scoreboard: watches the request, result and register ports of the tracker,
// predicts every result and compares it field by field; depends on rgrt_pkg
`default_nettype none
module rgrt_scoreboard (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   input  wire logic                            req_tready,
   input  wire logic [rgrt_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic                            req_tuser,
   input  wire logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   input  wire logic [rgrt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic [rgrt_pkg::OUTC_W-1:0]     rsp_tuser,
   input  wire logic                            csr_we,
   input  wire logic [rgrt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [rgrt_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                                   fail_count,
   output int                                   outstanding
);
   import rgrt_pkg::*;

   localparam int ENTRIES = RESEND_ENTRIES_DEF;

   typedef struct {
      logic [OUTC_W-1:0] outcome;
      logic [MS_W-1:0]   ts_ms;
      logic              req_valid;
      logic [SEQ_W-1:0]  req_number;
      logic [SEQ_W-1:0]  req_start;
      logic [SEQ_W-1:0]  req_count;
      logic [MS_W-1:0]   hold_ts;
      logic [EXP_W-1:0]  expired;
      logic              overflow;
   } tracker_result;

   tracker_result result_q[$];

   // mirrored registers and tracker state
   logic              ready_r;
   logic [RATE_W-1:0] rate_r;
   logic [TMO_W-1:0]  tmo_r;
   logic [SEQ_W-1:0]  next_seq;
   logic              active;
   logic [SEQ_W-1:0]  req_ctr;
   logic              ent_valid [ENTRIES];
   logic [SEQ_W-1:0]  ent_seq   [ENTRIES];
   logic [MS_W-1:0]   ent_time  [ENTRIES];
   logic [MS_W-1:0]   hold_r;

   function automatic logic [MS_W-1:0] frames_to_ms(logic [TS_W-1:0] ts);
      logic [63:0] q;
      if (rate_r == 0) return MS_MAX;
      q = (64'(ts) * 64'd1000) / 64'(rate_r);
      return (q > 64'(MS_MAX)) ? MS_MAX : q[MS_W-1:0];
   endfunction

   function automatic int lookup(logic [SEQ_W-1:0] s);
      for (int i = 0; i < ENTRIES; i++)
         if (ent_valid[i] && ent_seq[i] == s) return i;
      return -1;
   endfunction

   function automatic bit none_pending();
      for (int i = 0; i < ENTRIES; i++)
         if (ent_valid[i]) return 0;
      return 1;
   endfunction

   // store missing numbers, refresh ones already present; 1 when some are dropped
   function automatic bit store_gap(logic [SEQ_W-1:0] first, int unsigned n,
                                    logic [MS_W-1:0] t);
      int unsigned matched, free_n, placed;
      int slot;
      logic [SEQ_W-1:0] s, diff;
      matched = 0; free_n = 0; placed = 0; slot = 0;
      for (int i = 0; i < ENTRIES; i++) begin
         diff = ent_seq[i] - first;
         if (!ent_valid[i]) begin
            free_n++;
         end else if (32'(diff) < n) begin
            ent_time[i] = t;
            matched++;
         end
      end
      for (int unsigned k = 0; k < n && placed < free_n; k++) begin
         s = first + SEQ_W'(k);
         if (lookup(s) >= 0) continue;
         while (slot < ENTRIES && ent_valid[slot]) slot++;
         if (slot >= ENTRIES) break;
         ent_valid[slot] = 1;
         ent_seq[slot]   = s;
         ent_time[slot]  = t;
         placed++;
      end
      return (n - matched) > free_n;
   endfunction

   function automatic tracker_result track_packet(logic cmd, logic [REQ_DATA_W-1:0] d);
      tracker_result r;
      logic [7:0]       first, kind;
      logic [SEQ_W-1:0] s, gap;
      logic [TS_W-1:0]  ts;
      logic [31:0]      oldest;
      bit               any;
      int               hit;
      first = d[7:0]; kind = d[15:8]; s = d[31:16]; ts = d[63:32];
      r = '{default: '0};
      if (cmd) begin
         foreach (ent_valid[i]) ent_valid[i] = 0;
         active = 0;
         hold_r = '0;
         r.outcome = OUT_FLUSHED;
      end else if (first != HDR_V2 && first != HDR_V2_MARK) begin
         r.outcome = OUT_BAD_VERSION;
      end else begin
         if (kind != TYPE_SYNC_START && kind != TYPE_AUDIO_START) kind[7] = 1'b0;
         if (kind == TYPE_SYNC_A || kind == TYPE_SYNC_B || kind == TYPE_SYNC_START) begin
            r.outcome = OUT_IGNORED;
         end else if (kind != TYPE_AUDIO && kind != TYPE_AUDIO_START
                      && kind != TYPE_RESEND) begin
            r.outcome = OUT_UNHANDLED;
         end else if (!ready_r) begin
            r.outcome = OUT_NOT_READY;
         end else begin
            r.ts_ms = frames_to_ms(ts);
            if (kind == TYPE_RESEND) begin
               hit = lookup(s);
               if (hit >= 0) begin
                  ent_valid[hit] = 0;
                  r.outcome = OUT_RESEND_HIT;
               end else begin
                  r.outcome = OUT_RESEND_MISS;
               end
               if (none_pending()) hold_r = '0;
            end else begin
               r.outcome = OUT_AUDIO;
               if (kind == TYPE_AUDIO_START) begin
                  next_seq = s;
                  active = 1;
               end
               if (active && s != next_seq) begin
                  gap = s - next_seq;
                  r.req_valid  = 1;
                  r.req_number = req_ctr;
                  r.req_start  = next_seq;
                  r.req_count  = gap;
                  req_ctr++;
                  // backward jumps request but store nothing
                  if (gap < GAP_LIMIT && store_gap(next_seq, 32'(gap), r.ts_ms))
                     r.overflow = 1;
               end
               next_seq = s + 1'b1;
               active = 1;
               if (none_pending()) begin
                  hold_r = '0;
               end else begin
                  oldest = '1;
                  any = 0;
                  for (int i = 0; i < ENTRIES; i++) begin
                     if (!ent_valid[i]) continue;
                     // entries from the future count as aged out too
                     if (ent_time[i] > r.ts_ms || 32'(r.ts_ms - ent_time[i]) > 32'(tmo_r)) begin
                        ent_valid[i] = 0;
                        if (r.expired != '1) r.expired++;
                     end else begin
                        any = 1;
                        if (32'(ent_time[i]) < oldest) oldest = 32'(ent_time[i]);
                     end
                  end
                  hold_r = any ? oldest[MS_W-1:0] : '0;
               end
            end
         end
      end
      r.hold_ts = hold_r;
      return r;
   endfunction

   task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      tracker_result want;
      if (reset) begin
         ready_r = 0; rate_r = RATE_RESET; tmo_r = TMO_RESET;
         next_seq = '0; active = 0; req_ctr = '0; hold_r = '0;
         foreach (ent_valid[i]) ent_valid[i] = 0;
         result_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SESSION_READY: ready_r = csr_wdata[0];
               CSR_SAMPLE_RATE:   rate_r  = csr_wdata[RATE_W-1:0];
               CSR_RESEND_TMO:    tmo_r   = csr_wdata[TMO_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            result_q.push_back(track_packet(req_tuser, req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (result_q.size() == 0) begin
               $error("result beat with no expectation waiting");
               fail_count++;
            end else begin
               want = result_q.pop_front();
               compare_field("outcome", want.outcome, rsp_tuser);
               compare_field("timestamp_ms", want.ts_ms, rsp_tdata[28:0]);
               compare_field("request_valid", want.req_valid, rsp_tdata[29]);
               compare_field("request_number", want.req_number, rsp_tdata[45:30]);
               compare_field("request_start", want.req_start, rsp_tdata[61:46]);
               compare_field("request_count", want.req_count, rsp_tdata[77:62]);
               compare_field("hold_timestamp", want.hold_ts, rsp_tdata[106:78]);
               compare_field("expired_count", want.expired, rsp_tdata[113:107]);
               compare_field("table_overflow", want.overflow, rsp_tdata[114]);
               compare_field("pad", '0, rsp_tdata[119:115]);
            end
         end
      end
      outstanding = result_q.size();
   end

   initial begin
      fail_count = 0;
      outstanding = 0;
   end

endmodule
`default_nettype wire

### tb/rtp_gap_resend_tracker_tb.sv
// rtp_gap_resend_tracker_tb: drives packet headers, flushes and register writes
// into the tracker; depends on rgrt_pkg, rgrt_scoreboard and the tracker rtl
`default_nettype none
module rtp_gap_resend_tracker_tb;
   import rgrt_pkg::*;

   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int RANDOM_ITEMS = 600;
   localparam int DRAIN_CYCLES = 400;    // idle cycles after the final drain

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_tvalid = 0;
   logic                  req_tready;
   // [7:0] first_byte, [15:8] type_byte, [31:16] sequence_req, [63:32] rtp_timestamp
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   // [0] command
   logic                  req_tuser = 0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 0;
   // [28:0] timestamp_ms, [29] request_valid, [45:30] request_number,
   // [61:46] request_start, [77:62] request_count, [106:78] hold_timestamp,
   // [113:107] expired_count, [114] table_overflow, [119:115] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // [2:0] outcome
   logic [OUTC_W-1:0]     rsp_tuser;
   logic                  csr_we = 0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int fail_count;
   int outstanding;
   int cycle_count = 0;

   // idle percentages per phase, and the long receiver hold-off
   int sender_idle = 0;
   int receiver_idle = 0;
   int hold_off_cycles = 0;

   // stream state on the stimulus side
   logic [SEQ_W-1:0] stream_seq;
   logic [TS_W-1:0]  stream_ts;

   rtp_gap_resend_tracker dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   rgrt_scoreboard checker_i (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .outstanding(outstanding)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("rtp_gap_resend_tracker verification failed");
         $finish;
      end
   end

   // result side: random back-pressure, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_off_cycles = hold_off_cycles - 1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= receiver_idle);
         end
      end
   end

   // offer one beat; valid stays high from the previous beat unless we idle
   task automatic send_beat(logic cmd, logic [7:0] first, logic [7:0] kind,
                            logic [SEQ_W-1:0] s, logic [TS_W-1:0] ts);
      while ($urandom_range(99) < sender_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {ts, s, kind, first};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic audio(logic [7:0] kind, logic [SEQ_W-1:0] s, logic [TS_W-1:0] ts);
      send_beat(1'b0, HDR_V2, kind, s, ts);
   endtask

   // stop offering and wait for every expected result to arrive
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // registers only change while the tracker is idle
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      drain();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_session(logic rdy, logic [RATE_W-1:0] rate, logic [TMO_W-1:0] tmo);
      write_reg(CSR_SESSION_READY, CSR_DATA_W'(rdy));
      write_reg(CSR_SAMPLE_RATE, CSR_DATA_W'(rate));
      write_reg(CSR_RESEND_TMO, CSR_DATA_W'(tmo));
   endtask

   // one random beat, mostly a well-formed stream with gaps and resends
   task automatic random_beat();
      int pick;
      pick = $urandom_range(99);
      if (pick < 2) begin
         send_beat(1'b1, 8'($urandom), 8'($urandom), 16'($urandom), $urandom);
      end else if (pick < 10) begin
         // noise: any header byte, any type
         send_beat(1'b0, ($urandom_range(1) ? 8'($urandom) : HDR_V2_MARK),
                   8'($urandom), 16'($urandom), $urandom);
      end else if (pick < 14) begin
         stream_seq = 16'($urandom);
         stream_ts  = ($urandom_range(3) == 0) ? $urandom : stream_ts;
         audio(TYPE_AUDIO_START, stream_seq, stream_ts);
         stream_seq++;
      end else if (pick < 30) begin
         // resend of a recent number, usually one that went missing
         audio(TYPE_RESEND, stream_seq - 16'($urandom_range(1, 12)),
               stream_ts - $urandom_range(0, 2000));
      end else begin
         case ($urandom_range(9))
            0, 1:    stream_seq += 16'($urandom_range(1, 6));
            2:       stream_seq += 16'($urandom_range(7, 80));
            3:       if ($urandom_range(7) == 0) stream_seq += 16'($urandom);
            default: ;
         endcase
         stream_ts += $urandom_range(100, 30000);
         audio(($urandom_range(1) ? TYPE_AUDIO : (TYPE_AUDIO | 8'h80)), stream_seq,
               ($urandom_range(19) == 0) ? $urandom : stream_ts);
         stream_seq++;
      end
   endtask

   initial begin
      stream_seq = '0;
      stream_ts  = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed part ---
      // audio before the session is ready is refused
      audio(TYPE_AUDIO, 16'd5, 32'd1000);
      set_session(1'b1, 18'd44100, 16'd500);
      send_beat(1'b1, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
      send_beat(1'b0, 8'h00, TYPE_AUDIO, 16'd1, 32'd1);
      send_beat(1'b0, 8'hFF, TYPE_AUDIO, 16'd1, 32'd1);
      send_beat(1'b0, HDR_V2_MARK, TYPE_SYNC_A, 16'd0, 32'd0);
      audio(TYPE_SYNC_B, 16'd0, 32'd0);
      audio(TYPE_SYNC_START, 16'd0, 32'd0);
      audio(8'hD3, 16'd0, 32'd0);              // high bit dropped, sync
      audio(8'hE1, 16'd0, 32'd0);              // high bit dropped, unhandled
      audio(8'h12, 16'd0, 32'd0);
      // stream start near the wrap, then a gap across it
      audio(TYPE_AUDIO_START, 16'hFFFE, 32'd0);
      audio(TYPE_AUDIO, 16'hFFFF, 32'd44100);
      audio(TYPE_AUDIO, 16'd3, 32'd88200);
      audio(TYPE_RESEND, 16'd1, 32'd60000);    // matched
      audio(TYPE_RESEND, 16'h1234, 32'd60000); // unknown
      // gap larger than the free table space overflows
      audio(TYPE_AUDIO, 16'd104, 32'd90000);
      // overlapping gap refreshes existing entries
      audio(TYPE_AUDIO_START, 16'd50, 32'd95000);
      audio(TYPE_AUDIO, 16'd120, 32'd96000);
      // backward jump requests but stores nothing
      audio(TYPE_AUDIO, 16'd10, 32'd97000);
      // older packet time makes every entry a future one
      audio(TYPE_AUDIO, 16'd11, 32'd5);
      // outstanding entry at time zero keeps the hold at zero
      audio(TYPE_AUDIO_START, 16'd200, 32'd0);
      audio(TYPE_AUDIO, 16'd202, 32'd0);
      audio(TYPE_AUDIO, 16'd203, 32'hFFFF_FFFF);
      send_beat(1'b1, 8'h00, 8'h00, 16'h0000, 32'h0);
      // zero and tiny sample rates saturate the millisecond value, the largest rate does not
      write_reg(CSR_SAMPLE_RATE, '0);
      audio(TYPE_AUDIO, 16'd300, 32'd7);
      write_reg(CSR_SAMPLE_RATE, 18'h3FFFF);
      write_reg(CSR_RESEND_TMO, 16'hFFFF);
      audio(TYPE_AUDIO, 16'd310, 32'hFFFF_FFFF);
      write_reg(CSR_SAMPLE_RATE, 18'd1);
      audio(TYPE_AUDIO, 16'd311, 32'hFFFF_FFFF);

      // --- random part in three idling phases ---
      set_session(1'b1, 18'd44100, 16'd500);
      sender_idle = 9; receiver_idle = 83;
      for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
         if (n == 100) begin
            drain();                           // sender waits for the tracker to empty
         end
         random_beat();
      end

      set_session(1'b1, 18'd8000, 16'd0);
      sender_idle = 83; receiver_idle = 9;
      for (int n = 0; n < RANDOM_ITEMS / 3; n++) random_beat();

      set_session(1'b1, 18'd192000, 16'd65535);
      sender_idle = 0; receiver_idle = 0;
      hold_off_cycles = 3000;                  // tracker fills and stalls its input
      for (int n = 0; n < RANDOM_ITEMS / 3; n++) random_beat();

      // session dropped: audio refused again
      write_reg(CSR_SESSION_READY, '0);
      for (int n = 0; n < 10; n++) random_beat();

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("rtp_gap_resend_tracker verification clean");
      end else begin
         $display("rtp_gap_resend_tracker verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

### filelist.f
hdl/rgrt_pkg.sv
hdl/rgrt_ms_conv.sv
hdl/rtp_gap_resend_tracker.sv
tb/rgrt_scoreboard.sv
tb/rtp_gap_resend_tracker_tb.sv
